// ===== rtl/rncc_pkg.sv =====
// shared types and constants for the rgb normalized correlation unit
`timescale 1ns / 1ps

package rncc_pkg;

    localparam int CHAN_W           = 8;
    localparam int CHANNEL_BITS_DEF = 8;
    localparam int N_CHAN           = 3;
    localparam int N_PROD           = 3 * N_CHAN;
    localparam int STEP_W           = $clog2(N_PROD + 1);

    localparam int SUM_W            = 30;
    localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

    localparam int PROD_W           = 2 * SUM_W;
    localparam int ROOT_W           = PROD_W / 2;
    localparam int FRAC_SHIFT       = 16;
    localparam int NUM_W            = SUM_W + FRAC_SHIFT + 1;
    localparam int FRAC_W           = FRAC_SHIFT + 1;
    localparam logic [FRAC_W-1:0] ONE_Q16 = FRAC_W'(1 << FRAC_SHIFT);

    typedef struct packed {
        logic busy;
        logic done;
    } unit_stat_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_CHECK,
        ST_ROOT_GO,
        ST_ROOT_WAIT,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_OUT
    } state_t;

endpackage

// ===== rtl/rncc_in_if.sv =====
// pixel pair channel
`timescale 1ns / 1ps

interface rncc_in_if;

    logic                      valid;
    logic                      ready;
    logic [rncc_pkg::CHAN_W-1:0] first_red;
    logic [rncc_pkg::CHAN_W-1:0] first_green;
    logic [rncc_pkg::CHAN_W-1:0] first_blue;
    logic [rncc_pkg::CHAN_W-1:0] second_red;
    logic [rncc_pkg::CHAN_W-1:0] second_green;
    logic [rncc_pkg::CHAN_W-1:0] second_blue;
    logic                      last_pixel;

    modport source (
        output valid, first_red, first_green, first_blue,
               second_red, second_green, second_blue, last_pixel,
        input  ready
    );

    modport sink (
        input  valid, first_red, first_green, first_blue,
               second_red, second_green, second_blue, last_pixel,
        output ready
    );

endinterface

// ===== rtl/rncc_out_if.sv =====
// correlation result channel
`timescale 1ns / 1ps

interface rncc_out_if;

    logic                        valid;
    logic                        ready;
    logic [rncc_pkg::FRAC_W-1:0] ncc_fraction;
    logic                        zero_energy;

    modport source (
        output valid, ncc_fraction, zero_energy,
        input  ready
    );

    modport sink (
        input  valid, ncc_fraction, zero_energy,
        output ready
    );

endinterface

// ===== rtl/rncc_isqrt.sv =====
// iterative integer square root, two radicand bits per cycle
`timescale 1ns / 1ps

module rncc_isqrt (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [rncc_pkg::PROD_W-1:0]   radicand,
    output logic [rncc_pkg::ROOT_W-1:0]   root,
    output rncc_pkg::unit_stat_t          stat
);

    localparam int PW    = rncc_pkg::PROD_W;
    localparam int RW    = rncc_pkg::ROOT_W;
    localparam int REM_W = RW + 3;
    localparam int CNT_W = $clog2(RW);

    logic [PW-1:0]    x_reg, x_next;
    logic [REM_W-1:0] rem_reg, rem_next;
    logic [RW-1:0]    root_reg, root_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;

    logic [REM_W-1:0] rem_sh;
    logic [REM_W-1:0] trial;

    assign rem_sh = {rem_reg[REM_W-3:0], x_reg[PW-1:PW-2]};
    assign trial  = {1'b0, root_reg, 2'b01};

    always_comb
    begin
        x_next    = x_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            x_next    = radicand;
            rem_next  = '0;
            root_next = '0;
            cnt_next  = CNT_W'(RW - 1);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            x_next = {x_reg[PW-3:0], 2'b00};
            if (rem_sh >= trial)
            begin
                rem_next  = rem_sh - trial;
                root_next = {root_reg[RW-2:0], 1'b1};
            end
            else
            begin
                rem_next  = rem_sh;
                root_next = {root_reg[RW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg    <= x_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign root      = root_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

// ===== rtl/rncc_div.sv =====
// restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps

module rncc_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [rncc_pkg::NUM_W-1:0]    numerator,
    input  logic [rncc_pkg::ROOT_W-1:0]   denominator,
    output logic [rncc_pkg::NUM_W-1:0]    quotient,
    output rncc_pkg::unit_stat_t          stat
);

    localparam int NW    = rncc_pkg::NUM_W;
    localparam int DW    = rncc_pkg::ROOT_W;
    localparam int CNT_W = $clog2(NW);

    logic [NW-1:0]    num_reg, num_next;
    logic [DW-1:0]    den_reg, den_next;
    logic [DW-1:0]    rem_reg, rem_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;

    logic [DW:0]      rem_sh;
    logic [DW:0]      rem_sub;

    assign rem_sh  = {rem_reg, num_reg[NW-1]};
    assign rem_sub = rem_sh - {1'b0, den_reg};

    always_comb
    begin
        num_next  = num_reg;
        den_next  = den_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            num_next  = numerator;
            den_next  = denominator;
            rem_next  = '0;
            cnt_next  = CNT_W'(NW - 1);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (rem_sh >= {1'b0, den_reg})
            begin
                rem_next = rem_sub[DW-1:0];
                num_next = {num_reg[NW-2:0], 1'b1};
            end
            else
            begin
                rem_next = rem_sh[DW-1:0];
                num_next = {num_reg[NW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        den_reg <= den_next;
        rem_reg <= rem_next;
    end

    assign quotient  = num_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

// ===== rtl/rgb_normalized_correlation_unit.sv =====
// top level: patch sums on a shared multiplier, then square root and divide
// a pixel pair is taken only in idle, so not while one is in work: its nine products go
// through the one 30x30 multiplier, with one register stage before each sum update
// a last pair adds the energy product, then the square root, then the divide
// results sit in an output register, so the next pair is taken while one waits
// reset clears the three sums, the sequencer and the output valid flag
`timescale 1ns / 1ps

module rgb_normalized_correlation_unit #(
    parameter int CHANNEL_BITS = rncc_pkg::CHANNEL_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    rncc_in_if.sink     pix,
    rncc_out_if.source  res
);

    localparam int CW = rncc_pkg::CHAN_W;
    localparam int SW = rncc_pkg::SUM_W;
    localparam int PW = rncc_pkg::PROD_W;
    localparam int RW = rncc_pkg::ROOT_W;
    localparam int NW = rncc_pkg::NUM_W;
    localparam int FW = rncc_pkg::FRAC_W;
    localparam int TW = rncc_pkg::STEP_W;
    localparam logic [CW-1:0] CHAN_MASK = CW'((1 << CHANNEL_BITS) - 1);

    rncc_pkg::state_t state_reg, state_next;
    logic [TW-1:0]    step_reg, step_next;
    logic [TW-1:0]    acc_idx;

    logic [CW-1:0]    a_reg [rncc_pkg::N_CHAN];
    logic [CW-1:0]    b_reg [rncc_pkg::N_CHAN];
    logic             last_reg;

    logic [SW-1:0]    cross_reg, cross_next;
    logic [SW-1:0]    fe_reg, fe_next;
    logic [SW-1:0]    se_reg, se_next;

    logic             mul_en;
    logic [SW-1:0]    mul_a, mul_b;
    logic [PW-1:0]    mul_out;
    logic [PW-1:0]    prod_reg;

    logic [FW-1:0]    frac_reg, frac_next;
    logic             zero_reg, zero_next;
    logic             out_valid_reg, out_valid_next;
    logic [FW-1:0]    out_frac_reg;
    logic             out_zero_reg;
    logic             out_load;

    logic             root_start;
    logic [RW-1:0]    root;
    rncc_pkg::unit_stat_t root_stat;

    logic             div_start;
    logic [NW-1:0]    div_num;
    logic [NW-1:0]    div_num_round;
    logic [NW-1:0]    quotient;
    rncc_pkg::unit_stat_t div_stat;

    logic             pix_take;

    function automatic logic [SW-1:0] sat_add(input logic [SW-1:0] acc,
                                              input logic [SW-1:0] inc);
        logic [SW:0] s;
        s = {1'b0, acc} + {1'b0, inc};
        return s[SW] ? rncc_pkg::SUM_MAX : s[SW-1:0];
    endfunction

    rncc_isqrt u_isqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (root_start),
        .radicand (prod_reg),
        .root     (root),
        .stat     (root_stat)
    );

    rncc_div u_div (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (div_start),
        .numerator   (div_num_round),
        .denominator (root),
        .quotient    (quotient),
        .stat        (div_stat)
    );

    assign pix.ready = (state_reg == rncc_pkg::ST_IDLE);
    assign pix_take  = pix.valid && pix.ready;
    assign acc_idx   = step_reg - 1'b1;
    assign mul_out   = mul_a * mul_b;
    assign div_num   = {cross_reg, {rncc_pkg::FRAC_SHIFT{1'b0}}, 1'b0} >> 1;

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        cross_next = cross_reg;
        fe_next    = fe_reg;
        se_next    = se_reg;
        frac_next  = frac_reg;
        zero_next  = zero_reg;
        mul_en     = 1'b0;
        mul_a      = '0;
        mul_b      = '0;
        root_start = 1'b0;
        div_start  = 1'b0;
        out_load   = 1'b0;
        unique case (state_reg)
            rncc_pkg::ST_IDLE:
            begin
                step_next = '0;
                if (pix_take)
                begin
                    state_next = rncc_pkg::ST_MUL;
                end
            end
            rncc_pkg::ST_MUL:
            begin
                if (step_reg < TW'(rncc_pkg::N_PROD))
                begin
                    mul_en = 1'b1;
                    case (step_reg)
                        TW'(0): begin mul_a = SW'(a_reg[0]); mul_b = SW'(b_reg[0]); end
                        TW'(1): begin mul_a = SW'(a_reg[1]); mul_b = SW'(b_reg[1]); end
                        TW'(2): begin mul_a = SW'(a_reg[2]); mul_b = SW'(b_reg[2]); end
                        TW'(3): begin mul_a = SW'(a_reg[0]); mul_b = SW'(a_reg[0]); end
                        TW'(4): begin mul_a = SW'(a_reg[1]); mul_b = SW'(a_reg[1]); end
                        TW'(5): begin mul_a = SW'(a_reg[2]); mul_b = SW'(a_reg[2]); end
                        TW'(6): begin mul_a = SW'(b_reg[0]); mul_b = SW'(b_reg[0]); end
                        TW'(7): begin mul_a = SW'(b_reg[1]); mul_b = SW'(b_reg[1]); end
                        default: begin mul_a = SW'(b_reg[2]); mul_b = SW'(b_reg[2]); end
                    endcase
                end
                if (step_reg != '0)
                begin
                    case (acc_idx) inside
                        TW'(0), TW'(1), TW'(2):
                            cross_next = sat_add(cross_reg, prod_reg[SW-1:0]);
                        TW'(3), TW'(4), TW'(5):
                            fe_next = sat_add(fe_reg, prod_reg[SW-1:0]);
                        default:
                            se_next = sat_add(se_reg, prod_reg[SW-1:0]);
                    endcase
                end
                step_next = step_reg + 1'b1;
                if (step_reg == TW'(rncc_pkg::N_PROD))
                begin
                    step_next  = '0;
                    state_next = last_reg ? rncc_pkg::ST_CHECK : rncc_pkg::ST_IDLE;
                end
            end
            rncc_pkg::ST_CHECK:
            begin
                if (fe_reg == '0 || se_reg == '0)
                begin
                    frac_next  = '0;
                    zero_next  = 1'b1;
                    state_next = rncc_pkg::ST_OUT;
                end
                else
                begin
                    mul_en     = 1'b1;
                    mul_a      = fe_reg;
                    mul_b      = se_reg;
                    state_next = rncc_pkg::ST_ROOT_GO;
                end
            end
            rncc_pkg::ST_ROOT_GO:
            begin
                root_start = 1'b1;
                state_next = rncc_pkg::ST_ROOT_WAIT;
            end
            rncc_pkg::ST_ROOT_WAIT:
            begin
                if (root_stat.done)
                begin
                    state_next = rncc_pkg::ST_DIV_GO;
                end
            end
            rncc_pkg::ST_DIV_GO:
            begin
                div_start  = 1'b1;
                state_next = rncc_pkg::ST_DIV_WAIT;
            end
            rncc_pkg::ST_DIV_WAIT:
            begin
                if (div_stat.done)
                begin
                    if (quotient > NW'(rncc_pkg::ONE_Q16))
                    begin
                        frac_next = rncc_pkg::ONE_Q16;
                    end
                    else
                    begin
                        frac_next = quotient[FW-1:0];
                    end
                    zero_next  = 1'b0;
                    state_next = rncc_pkg::ST_OUT;
                end
            end
            rncc_pkg::ST_OUT:
            begin
                if (!out_valid_reg || res.ready)
                begin
                    out_load   = 1'b1;
                    cross_next = '0;
                    fe_next    = '0;
                    se_next    = '0;
                    state_next = rncc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = rncc_pkg::ST_IDLE;
            end
        endcase
    end

    // rounding term: half the root added on top of the shifted cross sum
    assign div_num_round = div_num + NW'(root >> 1);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (res.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= rncc_pkg::ST_IDLE;
            step_reg      <= '0;
            cross_reg     <= '0;
            fe_reg        <= '0;
            se_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            cross_reg     <= cross_next;
            fe_reg        <= fe_next;
            se_reg        <= se_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pix_take)
        begin
            a_reg[0] <= pix.first_red    & CHAN_MASK;
            a_reg[1] <= pix.first_green  & CHAN_MASK;
            a_reg[2] <= pix.first_blue   & CHAN_MASK;
            b_reg[0] <= pix.second_red   & CHAN_MASK;
            b_reg[1] <= pix.second_green & CHAN_MASK;
            b_reg[2] <= pix.second_blue  & CHAN_MASK;
            last_reg <= pix.last_pixel;
        end
        if (mul_en)
        begin
            prod_reg <= mul_out;
        end
        frac_reg <= frac_next;
        zero_reg <= zero_next;
        if (out_load)
        begin
            out_frac_reg <= frac_reg;
            out_zero_reg <= zero_reg;
        end
    end

    assign res.valid        = out_valid_reg;
    assign res.ncc_fraction = out_frac_reg;
    assign res.zero_energy  = out_zero_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && res.zero_energy |-> res.ncc_fraction == '0)
        else $error("zero energy result with nonzero fraction");

    assert property (@(posedge clk) disable iff (!rst_n)
        res.valid |-> res.ncc_fraction <= rncc_pkg::ONE_Q16)
        else $error("fraction above one");

    assert property (@(posedge clk) disable iff (!rst_n)
        root_stat.busy || div_stat.busy |-> !root_start && !div_start)
        else $error("arithmetic unit restarted while busy");

    assert property (@(posedge clk) disable iff (!rst_n)
        pix.valid && pix.ready |=> !pix.ready)
        else $error("pixel pair taken while previous pair in work");

endmodule
